>>> rtl/bdsd_pkg.sv
// Shared types and constants for the BCD digit scan driver.
// No dependencies; imported by every module of the block.
package bdsd_pkg;

  localparam int MAX_DIGITS_DEFAULT = 10;
  localparam int VALUE_W            = 32;
  localparam int COUNT_W            = 4;
  localparam int DIGIT_W            = 4;
  localparam int DIGIT_COUNT_RESET  = 3;

  // x / 10 == (x * DIV10_MAGIC) >> DIV10_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

endpackage

>>> rtl/bdsd_front.sv
// Front end: digit count register, input accept and binary-to-BCD conversion.
// One divide-by-ten step per cycle; depends on bdsd_pkg.
module bdsd_front import bdsd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  count_t                                cfg_wdata,
  input  logic                                  push,
  output logic                                  full,
  input  logic [VALUE_W-1:0]                    value,
  output logic                                  q_push,
  input  logic                                  q_full,
  output logic [COUNT_W+MAX_DIGITS*DIGIT_W-1:0] q_wdata
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  front_state_t                   state;
  count_t                         digit_count;
  count_t                         eff_count;
  count_t                         cnt;
  count_t                         widx;
  logic [VALUE_W-1:0]             rest;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [2*VALUE_W-1:0]           prod;
  logic [VALUE_W-1:0]             quot;
  logic [VALUE_W-1:0]             remd;

  always_comb begin
    eff_count = digit_count;
    if (digit_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (digit_count > COUNT_W'(MAX_DIGITS)) begin
      eff_count = COUNT_W'(MAX_DIGITS);
    end
  end

  assign prod = (2*VALUE_W)'(rest) * (2*VALUE_W)'(DIV10_MAGIC);
  assign quot = VALUE_W'(prod >> DIV10_SHIFT);
  assign remd = rest - ((quot << 3) + (quot << 1));

  assign full    = (state != F_IDLE);
  assign q_push  = (state == F_PUSH) && !q_full;
  assign q_wdata = {cnt, digits};

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_W'(DIGIT_COUNT_RESET);
    end else if (cfg_we) begin
      digit_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            state <= F_CONV;
          end
        end
        F_CONV: begin
          if (widx == '0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      rest <= value;
      cnt  <= eff_count;
      widx <= eff_count - COUNT_W'(1);
    end else if (state == F_CONV) begin
      digits[widx[IDX_W-1:0]] <= remd[DIGIT_W-1:0];
      rest <= quot;
      widx <= widx - COUNT_W'(1);
    end
  end

endmodule

>>> rtl/bdsd_queue.sv
// Two-entry queue carrying converted numbers from front end to scan back end.
// Depends on bdsd_pkg for the default WIDTH only.
module bdsd_queue import bdsd_pkg::*; #(
  parameter int WIDTH = COUNT_W + MAX_DIGITS_DEFAULT * DIGIT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/bdsd_back.sv
// Back end: scans one converted number out as digit beats, most significant first.
// Pops the queue and holds the output register; depends on bdsd_pkg.
module bdsd_back import bdsd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  q_pop,
  input  logic                                  q_empty,
  input  logic [COUNT_W+MAX_DIGITS*DIGIT_W-1:0] q_rdata,
  output logic                                  empty,
  input  logic                                  pop,
  output count_t                                digit_position,
  output digit_t                                bcd_digit,
  output logic                                  last
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                               valid;
  count_t                             cnt;
  count_t                             pos;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic                               done;

  assign last           = (pos + COUNT_W'(1) == cnt);
  assign done           = !valid || (pop && last);
  assign q_pop          = done && !q_empty;
  assign empty          = !valid;
  assign digit_position = pos;
  assign bcd_digit      = digits[pos[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (done) begin
      valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {cnt, digits} <= q_rdata;
      pos           <= '0;
    end else if (valid && pop) begin
      pos <= pos + COUNT_W'(1);
    end
  end

endmodule

>>> rtl/bcd_digit_scan_driver.sv
// Top level of the BCD digit scan driver: front end, two-entry queue, back end.
// Depends on bdsd_pkg, bdsd_front, bdsd_queue and bdsd_back.
//
// Each number pushed in is reduced modulo ten to the digit count (zero counts
// as one, counts above MAX_DIGITS saturate) and comes out as one beat per digit,
// most significant first, with last set on the final digit. The front end converts
// with one multiply-by-reciprocal divide-by-ten step per digit and holds full until
// the number is pushed into the queue; the back end emits one beat per cycle while
// pop is held. The two-entry queue between them lets the front end convert the next
// number while the back end scans. Write digit_count only while the block is idle.
module bcd_digit_scan_driver import bdsd_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  count_t             cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] value,
  output logic               empty,
  input  logic               pop,
  output count_t             digit_position,
  output digit_t             bcd_digit,
  output logic               last
);

  localparam int WORD_W = COUNT_W + MAX_DIGITS * DIGIT_W;

  logic              q_push;
  logic              q_full;
  logic [WORD_W-1:0] q_wdata;
  logic              q_pop;
  logic              q_empty;
  logic [WORD_W-1:0] q_rdata;

  bdsd_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .value     (value),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_wdata   (q_wdata)
  );

  bdsd_queue #(
    .WIDTH (WORD_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bdsd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .empty          (empty),
    .pop            (pop),
    .digit_position (digit_position),
    .bcd_digit      (bcd_digit),
    .last           (last)
  );

endmodule
